// ----- sv/dq_pkg.sv -----
// ----------------------------------------------------------------------------
// dq_pkg: shared types and constants for the bounded deque
// Sizes, operation and status codes, cell commands and control state.
// ----------------------------------------------------------------------------
package dq_pkg;

    localparam int DEPTH    = 16;
    localparam int IDX_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int DATA_W   = 32;
    localparam int POS_W    = 4;
    localparam int MODE_W   = 3;
    localparam int STATUS_W = 2;
    localparam int FOUND_W  = 4;
    localparam int COUNT_W  = 5;
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    // stream widths, padded to whole bytes
    localparam int IN_W  = 40;
    localparam int OUT_W = 112;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_FRONT = 3'd0,
        MODE_PUSH_BACK  = 3'd1,
        MODE_POP_FRONT  = 3'd2,
        MODE_POP_BACK   = 3'd3,
        MODE_SEARCH     = 3'd4,
        MODE_INSERT     = 3'd5,
        MODE_REMOVE_ALL = 3'd6,
        MODE_NOP        = 3'd7
    } mode_t;

    localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_PREV,
        CELL_NEXT
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     in_use;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_REMOVE,
        S_REPORT
    } state_t;

endpackage

// ----- sv/dq_cell.sv -----
// ----------------------------------------------------------------------------
// dq_cell: one storage cell of the deque
// Holds one word, takes a new word or a neighbour's word, and flags the
// first held word that equals the compare value along the chain.
// ----------------------------------------------------------------------------
module dq_cell (
    input  logic                       clk,
    input  dq_pkg::cell_ctrl_t         ctrl,
    input  logic [dq_pkg::DATA_W-1:0]  load_value,
    input  logic [dq_pkg::DATA_W-1:0]  prev_data,
    input  logic [dq_pkg::DATA_W-1:0]  next_data,
    input  logic [dq_pkg::DATA_W-1:0]  cmp_value,
    input  logic                       seen_in,
    output logic [dq_pkg::DATA_W-1:0]  data,
    output logic                       hit,
    output logic                       seen_out
);
    import dq_pkg::*;

    logic [DATA_W-1:0] data_reg;
    logic              match;

    always_ff @(posedge clk)
    begin
        case (ctrl.op)
            CELL_LOAD: data_reg <= load_value;
            CELL_PREV: data_reg <= prev_data;
            CELL_NEXT: data_reg <= next_data;
            default:   data_reg <= data_reg;
        endcase
    end

    assign match    = ctrl.in_use && (data_reg == cmp_value);
    assign hit      = match && !seen_in;
    assign seen_out = seen_in || match;
    assign data     = data_reg;

endmodule

// ----- sv/bounded_deque_with_value_removal.sv -----
// ----------------------------------------------------------------------------
// bounded_deque_with_value_removal: bounded deque of signed 32-bit words
// Row of shifting cells with a small controller and a registered result.
// ----------------------------------------------------------------------------
// Usage
//   s_axis: one operation per beat. tuser carries the mode, tdata carries
//   the value and the insert position.
//   m_axis: one result beat per operation. tuser carries the status, tdata
//   the popped word, found index, count, empty flag, front and back words.
// Timing
//   Push, pop, search and insert: the cell row shifts on the accepting edge
//   and the controller moves to the report state; the result register loads
//   from there once it is free. Remove-all: the row closes one gap per cycle,
//   one per matching entry; once no match is found the controller moves to
//   the report state, and the result register then loads in the same way.
//   A new operation is accepted once the previous result has been loaded
//   into the output register, so a new operation never overlaps the last.
// Reset
//   Asynchronous, active low. The store comes up empty; no result is valid.
// Back-pressure
//   While m_axis_tready is low the result is held; one more operation may
//   run, and its result waits in the controller until the register is free.
// ----------------------------------------------------------------------------
module bounded_deque_with_value_removal (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // tdata: value[31:0], position[35:32], zero pad[39:36]
    input  logic [dq_pkg::IN_W-1:0]   s_axis_tdata,
    // tuser: mode[2:0]
    input  logic [dq_pkg::MODE_W-1:0] s_axis_tuser,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // tdata: popped[31:0], found_index[35:32], entry_count[40:36],
    //        is_empty[41], front_value[73:42], back_value[105:74], pad[111:106]
    output logic [dq_pkg::OUT_W-1:0]  m_axis_tdata,
    // tuser: status[1:0]
    output logic [dq_pkg::STATUS_W-1:0] m_axis_tuser
);
    import dq_pkg::*;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]    count_reg, count_next;
    logic [STATUS_W-1:0] st_reg, st_next;
    logic [DATA_W-1:0]   popped_reg, popped_next;
    logic [IDX_W-1:0]    found_reg, found_next;
    logic [DATA_W-1:0]   val_reg;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [OUT_W-1:0]    out_data_reg;

    logic                in_acc;
    logic                out_load;
    mode_t               in_mode;
    logic [DATA_W-1:0]   in_value;
    logic [POS_W-1:0]    in_pos;
    logic                full;
    logic                empty;
    logic                pos_bad;
    logic [DATA_W-1:0]   cmp_value;
    logic [CNT_W-1:0]    count_m1;
    logic [DATA_W-1:0]   back_now;
    logic [DATA_W-1:0]   front_out;
    logic [DATA_W-1:0]   back_out;
    logic [IDX_W-1:0]    hit_idx;
    logic                any_hit;

    logic [DATA_W-1:0]   cell_data [DEPTH];
    cell_ctrl_t          cell_ctrl [DEPTH];
    logic [DEPTH-1:0]    hit;
    logic [DEPTH:0]      seen;

    assign in_mode  = mode_t'(s_axis_tuser);
    assign in_value = s_axis_tdata[DATA_W-1:0];
    assign in_pos   = s_axis_tdata[DATA_W +: POS_W];
    assign in_acc   = s_axis_tvalid && s_axis_tready;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pos_bad  = (CMP_W'(in_pos) >= CMP_W'(count_reg));
    assign count_m1 = count_reg - CNT_W'(1);
    assign back_now = cell_data[count_m1[IDX_W-1:0]];

    // compare against the incoming word on accept, the held one while removing
    assign cmp_value = (state_reg == S_IDLE) ? in_value : val_reg;
    assign seen[0]   = 1'b0;
    assign any_hit   = seen[DEPTH];

    always_comb
    begin
        hit_idx = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (hit[i])
            begin
                hit_idx = hit_idx | IDX_W'(i);
            end
        end
    end

    // ------------------------------------------------------------------
    // cell row
    // ------------------------------------------------------------------
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        localparam logic [CMP_W-1:0] IDX = CMP_W'(g);

        logic [DATA_W-1:0] prev_d;
        logic [DATA_W-1:0] next_d;

        if (g == 0)
        begin : g_first
            assign prev_d = cell_data[g];
        end
        else
        begin : g_mid
            assign prev_d = cell_data[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_last
            assign next_d = cell_data[g];
        end
        else
        begin : g_inner
            assign next_d = cell_data[g+1];
        end

        always_comb
        begin
            cell_ctrl[g].in_use = (IDX < CMP_W'(count_reg));
            cell_ctrl[g].op     = CELL_HOLD;
            if (state_reg == S_IDLE && in_acc)
            begin
                case (in_mode)
                    MODE_PUSH_FRONT:
                    begin
                        if (!full)
                        begin
                            cell_ctrl[g].op = (g == 0) ? CELL_LOAD : CELL_PREV;
                        end
                    end
                    MODE_PUSH_BACK:
                    begin
                        if (!full && IDX == CMP_W'(count_reg))
                        begin
                            cell_ctrl[g].op = CELL_LOAD;
                        end
                    end
                    MODE_POP_FRONT:
                    begin
                        if (!empty)
                        begin
                            cell_ctrl[g].op = CELL_NEXT;
                        end
                    end
                    MODE_INSERT:
                    begin
                        if (!pos_bad && !full)
                        begin
                            if (IDX == CMP_W'(in_pos))
                            begin
                                cell_ctrl[g].op = CELL_LOAD;
                            end
                            else if (IDX > CMP_W'(in_pos))
                            begin
                                cell_ctrl[g].op = CELL_PREV;
                            end
                        end
                    end
                    default:
                    begin
                        cell_ctrl[g].op = CELL_HOLD;
                    end
                endcase
            end
            else if (state_reg == S_REMOVE && seen[g+1])
            begin
                // close the gap at the first match and above
                cell_ctrl[g].op = CELL_NEXT;
            end
        end

        dq_cell u_cell (
            .clk        (clk),
            .ctrl       (cell_ctrl[g]),
            .load_value (in_value),
            .prev_data  (prev_d),
            .next_data  (next_d),
            .cmp_value  (cmp_value),
            .seen_in    (seen[g]),
            .data       (cell_data[g]),
            .hit        (hit[g]),
            .seen_out   (seen[g+1])
        );
    end

    // ------------------------------------------------------------------
    // operation bookkeeping
    // ------------------------------------------------------------------
    always_comb
    begin
        count_next  = count_reg;
        st_next     = st_reg;
        popped_next = popped_reg;
        found_next  = found_reg;
        if (state_reg == S_IDLE && in_acc)
        begin
            st_next     = ST_DONE;
            popped_next = '0;
            found_next  = '0;
            case (in_mode)
                MODE_PUSH_FRONT, MODE_PUSH_BACK:
                begin
                    if (full)
                    begin
                        st_next = ST_FULL;
                    end
                    else
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                MODE_POP_FRONT, MODE_POP_BACK:
                begin
                    if (empty)
                    begin
                        st_next = ST_MISS;
                    end
                    else
                    begin
                        popped_next = (in_mode == MODE_POP_FRONT) ? cell_data[0] : back_now;
                        count_next  = count_reg - CNT_W'(1);
                    end
                end
                MODE_SEARCH:
                begin
                    if (any_hit)
                    begin
                        found_next = hit_idx;
                    end
                    else
                    begin
                        st_next = ST_MISS;
                    end
                end
                MODE_INSERT:
                begin
                    if (pos_bad)
                    begin
                        st_next = ST_MISS;
                    end
                    else if (full)
                    begin
                        st_next = ST_FULL;
                    end
                    else
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                MODE_REMOVE_ALL:
                begin
                    // turned to done on the first removal
                    st_next = ST_MISS;
                end
                default:
                begin
                    st_next = ST_DONE;
                end
            endcase
        end
        else if (state_reg == S_REMOVE && any_hit)
        begin
            st_next    = ST_DONE;
            count_next = count_reg - CNT_W'(1);
        end
    end

    // ------------------------------------------------------------------
    // controller
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = (in_mode == MODE_REMOVE_ALL) ? S_REMOVE : S_REPORT;
                end
            end
            S_REMOVE:
            begin
                if (!any_hit)
                begin
                    state_next = S_REPORT;
                end
            end
            S_REPORT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_axis_tready = 1'b0;
        out_load      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_axis_tready = 1'b1;
            end
            S_REPORT:
            begin
                out_load = !out_valid_reg || m_axis_tready;
            end
            default:
            begin
                s_axis_tready = 1'b0;
                out_load      = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg     <= st_next;
        popped_reg <= popped_next;
        found_reg  <= found_next;
        if (in_acc)
        begin
            val_reg <= in_value;
        end
    end

    assign front_out = empty ? '0 : cell_data[0];
    assign back_out  = empty ? '0 : back_now;

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_status_reg <= st_reg;
            out_data_reg   <= {6'd0,
                               back_out,
                               front_out,
                               empty,
                               COUNT_W'(32'(count_reg)),
                               FOUND_W'(32'(found_reg)),
                               popped_reg};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = out_data_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_REMOVE |=> count_reg <= $past(count_reg))
        else $error("count grew during remove-all");

    a_full_refused: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && full && (in_mode == MODE_PUSH_FRONT || in_mode == MODE_PUSH_BACK))
        |=> (st_reg == ST_FULL && count_reg == $past(count_reg)))
        else $error("push into full store not refused");

    a_report_loads: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (m_axis_tvalid && state_reg == S_IDLE))
        else $error("result not presented after report");

    a_empty_front: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[41]) |-> (m_axis_tdata[105:42] == '0))
        else $error("empty result with non-zero front or back");

endmodule

// ----- tb/sv/deque_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deque_checker: result checker for the bounded deque
// Watches both stream channels, keeps its own copy of the store, predicts
// one report per accepted operation beat and compares every report beat,
// field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module deque_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    input  logic                          s_axis_tready,
    // tdata: value[31:0], position[35:32], zero pad[39:36]
    input  logic [dq_pkg::IN_W-1:0]       s_axis_tdata,
    // tuser: mode[2:0]
    input  logic [dq_pkg::MODE_W-1:0]     s_axis_tuser,
    input  logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // tdata: popped[31:0], found_index[35:32], entry_count[40:36],
    //        is_empty[41], front_value[73:42], back_value[105:74], pad[111:106]
    input  logic [dq_pkg::OUT_W-1:0]      m_axis_tdata,
    // tuser: status[1:0]
    input  logic [dq_pkg::STATUS_W-1:0]   m_axis_tuser,
    output int                            fail_count,
    output int                            pending
);

    import dq_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   popped;
        logic [FOUND_W-1:0]  found_index;
        logic [COUNT_W-1:0]  entry_count;
        logic                is_empty;
        logic [DATA_W-1:0]   front_value;
        logic [DATA_W-1:0]   back_value;
    } deque_report_t;

    logic [DATA_W-1:0] cells [DEPTH];
    int                held;
    int                mismatches;
    int                k;
    deque_report_t     report_queue [$];
    deque_report_t     want;
    deque_report_t     got;

    // applies one operation to the local store and forms its report
    function automatic deque_report_t deque_update(mode_t op, logic [DATA_W-1:0] word,
                                                   logic [POS_W-1:0] pos);
        deque_report_t r;
        int            i;
        int            keep;
        bit            hit;
        r        = '0;
        r.status = ST_DONE;
        hit      = 1'b0;
        case (op)
            MODE_PUSH_FRONT, MODE_PUSH_BACK:
            begin
                if (held >= DEPTH)
                    r.status = ST_FULL;
                else if (op == MODE_PUSH_FRONT)
                begin
                    for (i = held; i > 0; i--)
                        cells[i] = cells[i-1];
                    cells[0] = word;
                    held++;
                end
                else
                begin
                    cells[held] = word;
                    held++;
                end
            end
            MODE_POP_FRONT, MODE_POP_BACK:
            begin
                if (held == 0)
                    r.status = ST_MISS;
                else if (op == MODE_POP_FRONT)
                begin
                    r.popped = cells[0];
                    for (i = 0; i + 1 < held; i++)
                        cells[i] = cells[i+1];
                    held--;
                end
                else
                begin
                    r.popped = cells[held-1];
                    held--;
                end
            end
            MODE_SEARCH:
            begin
                r.status = ST_MISS;
                for (i = 0; i < held; i++)
                begin
                    if (!hit && cells[i] == word)
                    begin
                        hit           = 1'b1;
                        r.found_index = FOUND_W'(i);
                        r.status      = ST_DONE;
                    end
                end
            end
            MODE_INSERT:
            begin
                // position is checked before fullness
                if (int'(pos) >= held)
                    r.status = ST_MISS;
                else if (held >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    for (i = held; i > int'(pos); i--)
                        cells[i] = cells[i-1];
                    cells[pos] = word;
                    held++;
                end
            end
            MODE_REMOVE_ALL:
            begin
                keep = 0;
                for (i = 0; i < held; i++)
                begin
                    if (cells[i] != word)
                    begin
                        cells[keep] = cells[i];
                        keep++;
                    end
                end
                if (keep == held)
                    r.status = ST_MISS;
                held = keep;
            end
            default:
            begin
            end
        endcase
        r.entry_count = COUNT_W'(held);
        r.is_empty    = (held == 0);
        r.front_value = (held == 0) ? '0 : cells[0];
        r.back_value  = (held == 0) ? '0 : cells[held-1];
        return r;
    endfunction

    task automatic compare_field(string label, logic [DATA_W-1:0] exp_v,
                                 logic [DATA_W-1:0] act_v);
        if (act_v !== exp_v)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, label, exp_v, act_v);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held = 0;
            for (k = 0; k < DEPTH; k++)
                cells[k] = '0;
            report_queue.delete();
            pending <= 0;
        end
        else
        begin
            // the report beat always belongs to an older operation, so check it first
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.status      = m_axis_tuser;
                got.popped      = m_axis_tdata[31:0];
                got.found_index = m_axis_tdata[35:32];
                got.entry_count = m_axis_tdata[40:36];
                got.is_empty    = m_axis_tdata[41];
                got.front_value = m_axis_tdata[73:42];
                got.back_value  = m_axis_tdata[105:74];
                if (report_queue.size() == 0)
                begin
                    $display("%0t: unexpected report beat, expected none, got %0h",
                             $time, got);
                    mismatches++;
                end
                else
                begin
                    want = report_queue[0];
                    report_queue.delete(0);
                    compare_field("status", DATA_W'(want.status), DATA_W'(got.status));
                    compare_field("popped", want.popped, got.popped);
                    compare_field("found_index", DATA_W'(want.found_index),
                                  DATA_W'(got.found_index));
                    compare_field("entry_count", DATA_W'(want.entry_count),
                                  DATA_W'(got.entry_count));
                    compare_field("is_empty", DATA_W'(want.is_empty), DATA_W'(got.is_empty));
                    compare_field("front_value", want.front_value, got.front_value);
                    compare_field("back_value", want.back_value, got.back_value);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                report_queue.insert(report_queue.size(),
                                    deque_update(mode_t'(s_axis_tuser),
                                                 s_axis_tdata[31:0],
                                                 s_axis_tdata[35:32]));
            pending    <= report_queue.size();
            fail_count <= mismatches;
        end
    end

endmodule

// ----- tb/sv/tb_bounded_deque_with_value_removal.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bounded_deque_with_value_removal: stimulus and verdict for the deque
// Drives a directed run through the empty and full corners, then phases
// of random operations that alternately fill and drain the store, with
// bursty input and a stalling result side. Checking is done in deque_checker.
// ----------------------------------------------------------------------------
module tb_bounded_deque_with_value_removal;

    import dq_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASES       = 14;
    localparam int PHASE_OPS    = 100;

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [IN_W-1:0]     s_axis_tdata  = '0;
    logic [MODE_W-1:0]   s_axis_tuser  = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OUT_W-1:0]    m_axis_tdata;
    logic [STATUS_W-1:0] m_axis_tuser;

    int fail_count;
    int pending;
    int burst_left = 0;
    int idle_cycles = 0;
    int rx_hold = 0;
    logic [9:0] rx_tick = '0;

    logic [DATA_W-1:0] word_pool [6] = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF,
                                         32'h0000_0007, 32'h8000_0000, 32'h0000_1234};

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    bounded_deque_with_value_removal dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    deque_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    // result side: cycles through always-ready, coin-flip, long stalls, mostly stalled
    always @(posedge clk)
    begin
        rx_tick <= rx_tick + 10'd1;
        if (rx_hold > 0)
        begin
            m_axis_tready <= 1'b0;
            rx_hold       <= rx_hold - 1;
        end
        else
        begin
            case (rx_tick[9:8])
                2'd0: m_axis_tready <= 1'b1;
                2'd1: m_axis_tready <= 1'($urandom_range(0, 1));
                2'd2:
                begin
                    if ($urandom_range(0, 15) == 0)
                    begin
                        m_axis_tready <= 1'b0;
                        rx_hold       <= $urandom_range(4, 15);
                    end
                    else
                        m_axis_tready <= 1'b1;
                end
                default: m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // one operation beat; valid stays high across a burst
    task automatic send_op(mode_t op, logic [DATA_W-1:0] word, logic [POS_W-1:0] pos);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 24);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_W-POS_W-DATA_W){1'b0}}, pos, word};
        s_axis_tuser  <= op;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    function automatic mode_t pick_mode(bit filling);
        int roll;
        roll = $urandom_range(0, 99);
        if (filling)
        begin
            if (roll < 25) return MODE_PUSH_FRONT;
            if (roll < 50) return MODE_PUSH_BACK;
            if (roll < 55) return MODE_POP_FRONT;
            if (roll < 60) return MODE_POP_BACK;
            if (roll < 72) return MODE_SEARCH;
            if (roll < 86) return MODE_INSERT;
            if (roll < 95) return MODE_REMOVE_ALL;
            return MODE_NOP;
        end
        if (roll < 10) return MODE_PUSH_FRONT;
        if (roll < 20) return MODE_PUSH_BACK;
        if (roll < 45) return MODE_POP_FRONT;
        if (roll < 70) return MODE_POP_BACK;
        if (roll < 80) return MODE_SEARCH;
        if (roll < 88) return MODE_INSERT;
        if (roll < 98) return MODE_REMOVE_ALL;
        return MODE_NOP;
    endfunction

    // small pool so that search and remove hit often
    function automatic logic [DATA_W-1:0] pick_word();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll == 0) return 32'h8000_0000;
        if (roll == 1) return 32'h7FFF_FFFF;
        if (roll < 6) return $urandom();
        return word_pool[$urandom_range(0, 5)];
    endfunction

    initial
    begin
        mode_t            op;
        logic [POS_W-1:0] pos;
        int               phase;
        int               n;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty store corners
        send_op(MODE_POP_FRONT, 32'h0, 4'd0);
        send_op(MODE_POP_BACK, 32'h0, 4'd0);
        send_op(MODE_INSERT, 32'h55, 4'd0);
        send_op(MODE_SEARCH, 32'h0, 4'd0);
        send_op(MODE_REMOVE_ALL, 32'h0, 4'd0);
        send_op(MODE_NOP, 32'hFFFF_FFFF, 4'd15);
        send_op(MODE_PUSH_BACK, 32'h7FFF_FFFF, 4'd0);
        send_op(MODE_PUSH_FRONT, 32'h8000_0000, 4'd0);
        send_op(MODE_PUSH_BACK, 32'hFFFF_FFFF, 4'd0);
        send_op(MODE_SEARCH, 32'hFFFF_FFFF, 4'd0);
        send_op(MODE_INSERT, 32'h0, 4'd1);
        send_op(MODE_INSERT, 32'h1, 4'd15);
        repeat (DEPTH - 4) send_op(MODE_PUSH_BACK, 32'h5, 4'd0);
        // full store corners
        send_op(MODE_PUSH_FRONT, 32'h1, 4'd0);
        send_op(MODE_PUSH_BACK, 32'h1, 4'd0);
        send_op(MODE_INSERT, 32'h2, 4'd3);
        send_op(MODE_INSERT, 32'h2, 4'd15);
        send_op(MODE_SEARCH, 32'h5, 4'd0);
        send_op(MODE_REMOVE_ALL, 32'h5, 4'd0);
        send_op(MODE_REMOVE_ALL, 32'h5, 4'd0);
        send_op(MODE_POP_FRONT, 32'h0, 4'd0);
        send_op(MODE_POP_BACK, 32'h0, 4'd0);

        for (phase = 0; phase < PHASES; phase++)
        begin
            if (phase == PHASES / 2)
            begin
                // hold off until every report is back
                s_axis_tvalid <= 1'b0;
                burst_left = 0;
                @(posedge clk);
                while (pending != 0) @(posedge clk);
            end
            for (n = 0; n < PHASE_OPS; n++)
            begin
                op = pick_mode(phase % 2 == 0);
                if (op == MODE_INSERT && $urandom_range(0, 1) == 1)
                    pos = POS_W'($urandom_range(0, 3));
                else
                    pos = POS_W'($urandom_range(0, 15));
                send_op(op, pick_word(), pos);
            end
        end

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
